/* hdl/http_request_framer_assert.svh */
// http_request_framer_assert.svh: assertion macros for the request framer.
// Uses clk_i and rst_ni of the including module.
`ifndef HTTP_REQUEST_FRAMER_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_ASSERT_SVH

// same-cycle implication
`define HRF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hrf_pkg.sv */
// hrf_pkg: types, codes and constants of the HTTP request framer.
// No dependencies.
package hrf_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
  } hrf_in_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  byte_out;
    logic        line_end;
    logic        line_ok;
    logic [31:0] body_length;
    logic        request_done;
  } hrf_result_t;

  localparam logic [2:0] ROLE_DROP   = 3'd0;
  localparam logic [2:0] ROLE_METHOD = 3'd1;
  localparam logic [2:0] ROLE_TARGET = 3'd2;
  localparam logic [2:0] ROLE_REST   = 3'd3;
  localparam logic [2:0] ROLE_HEADER = 3'd4;
  localparam logic [2:0] ROLE_BODY   = 3'd5;

  localparam logic [1:0] PH_REQ  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [2:0] HP_TAG    = 3'd0;
  localparam logic [2:0] HP_COLON  = 3'd1;
  localparam logic [2:0] HP_BLANK  = 3'd2;
  localparam logic [2:0] HP_DIGITS = 3'd3;
  localparam logic [2:0] HP_ENDED  = 3'd4;
  localparam logic [2:0] HP_NEG    = 3'd5;
  localparam logic [2:0] HP_BAD    = 3'd6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [3:0] TAG_LEN = 4'd14;

  // "Content-Length"
  function automatic logic [7:0] tag_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/hrf_stream_if.sv */
// hrf_stream_if: valid/ready channel carrying one word of payload_t.
// Payload types come from hrf_pkg.
interface hrf_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/hrf_parser.sv */
// hrf_parser: request/header/body phase tracking and Content-Length decode.
// Result for the current byte is combinational; state advances on step_i. Uses hrf_pkg.
module hrf_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  output hrf_pkg::hrf_result_t result_o
);
  import hrf_pkg::*;

  logic [1:0]             phase_q, phase_d;
  logic                   at_line_start_q, at_line_start_d;
  logic [1:0]             space_count_q, space_count_d;
  logic [3:0]             tag_index_q, tag_index_d;
  logic                   tag_equal_q, tag_equal_d;
  logic [2:0]             header_part_q, header_part_d;
  logic [LENGTH_BITS-1:0] accum_q, accum_d;
  logic [LENGTH_BITS-1:0] length_q, length_d;
  logic [LENGTH_BITS-1:0] body_count_q, body_count_d;

  logic [7:0]             c;
  logic                   is_digit, is_blank;
  logic [LENGTH_BITS+3:0] prod;
  logic [LENGTH_BITS-1:0] accum_next;
  logic [LENGTH_BITS+31:0] len_ext;
  logic                   done;
  hrf_result_t            res;

  assign c        = data_byte_i;
  assign is_digit = c inside {[CH_ZERO:CH_NINE]};
  assign is_blank = (c == CH_SP) || (c inside {[CH_TAB:CH_CR]});

  // accum * 10 + digit, saturated
  always_comb begin
    prod = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1)
         + {{LENGTH_BITS{1'b0}}, c[3:0]};
    if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
      accum_next = '1;
    end else begin
      accum_next = prod[LENGTH_BITS-1:0];
    end
  end

  always_comb begin
    phase_d         = phase_q;
    at_line_start_d = at_line_start_q;
    space_count_d   = space_count_q;
    tag_index_d     = tag_index_q;
    tag_equal_d     = tag_equal_q;
    header_part_d   = header_part_q;
    accum_d         = accum_q;
    length_d        = length_q;
    body_count_d    = body_count_q;
    done            = 1'b0;
    res             = '0;
    res.byte_out    = c;

    case (phase_q)
      PH_HDR: begin
        if (c == CH_LF) begin
          if (at_line_start_q) begin
            if (length_q != '0) begin
              phase_d      = PH_BODY;
              body_count_d = '0;
            end else begin
              phase_d = PH_REQ;
              done    = 1'b1;
            end
          end else begin
            res.line_end = 1'b1;
            res.line_ok  = header_part_q inside {[HP_BLANK:HP_NEG]};
            if (res.line_ok && tag_equal_q && (header_part_q != HP_NEG)) begin
              length_d = accum_q;
            end
          end
          tag_index_d   = '0;
          tag_equal_d   = 1'b1;
          header_part_d = HP_TAG;
          accum_d       = '0;
        end else if (c != CH_CR) begin
          res.role = ROLE_HEADER;
          case (header_part_q)
            HP_TAG: begin
              if (c == CH_COLON) begin
                if (tag_index_q != TAG_LEN) tag_equal_d = 1'b0;
                header_part_d = HP_COLON;
              end else if ((tag_index_q < TAG_LEN) && (c == tag_char(tag_index_q))) begin
                tag_index_d = tag_index_q + 4'd1;
              end else begin
                tag_equal_d = 1'b0;
              end
            end
            HP_COLON: header_part_d = (c == CH_SP) ? HP_BLANK : HP_BAD;
            HP_BLANK: begin
              if (is_blank) begin
                header_part_d = HP_BLANK;
              end else if (c == CH_PLUS) begin
                header_part_d = HP_DIGITS;
              end else if (c == CH_MINUS) begin
                header_part_d = HP_NEG;
              end else if (is_digit) begin
                accum_d       = accum_next;
                header_part_d = HP_DIGITS;
              end else begin
                header_part_d = HP_ENDED;
              end
            end
            HP_DIGITS: begin
              if (is_digit) begin
                accum_d = accum_next;
              end else begin
                header_part_d = HP_ENDED;
              end
            end
            default: header_part_d = header_part_q;
          endcase
        end
      end
      PH_BODY: begin
        res.role     = ROLE_BODY;
        body_count_d = body_count_q + 1'b1;
        if (body_count_d == length_q) begin
          phase_d = PH_REQ;
          done    = 1'b1;
        end
      end
      default: begin
        if (c == CH_LF) begin
          res.line_end  = 1'b1;
          res.line_ok   = (space_count_q == 2'd2);
          space_count_d = 2'd0;
          tag_index_d   = '0;
          tag_equal_d   = 1'b1;
          header_part_d = HP_TAG;
          accum_d       = '0;
          phase_d       = PH_HDR;
        end else if (c != CH_CR) begin
          if ((c == CH_SP) && (space_count_q < 2'd2)) begin
            space_count_d = space_count_q + 2'd1;
          end
          case (space_count_d)
            2'd0:    res.role = ROLE_METHOD;
            2'd1:    res.role = ROLE_TARGET;
            default: res.role = ROLE_REST;
          endcase
        end
      end
    endcase

    if (c == CH_LF) begin
      at_line_start_d = 1'b1;
    end else if (c != CH_CR) begin
      at_line_start_d = 1'b0;
    end

    len_ext           = {32'd0, length_d};
    res.body_length   = len_ext[31:0];
    res.request_done  = done;
    if (done) begin
      length_d     = '0;
      body_count_d = '0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_REQ;
      at_line_start_q <= 1'b0;
      space_count_q   <= 2'd0;
      tag_index_q     <= '0;
      tag_equal_q     <= 1'b1;
      header_part_q   <= HP_TAG;
      accum_q         <= '0;
      length_q        <= '0;
      body_count_q    <= '0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      at_line_start_q <= at_line_start_d;
      space_count_q   <= space_count_d;
      tag_index_q     <= tag_index_d;
      tag_equal_q     <= tag_equal_d;
      header_part_q   <= header_part_d;
      accum_q         <= accum_d;
      length_q        <= length_d;
      body_count_q    <= body_count_d;
    end
  end

endmodule

/* hdl/http_request_framer.sv */
// http_request_framer: tags each byte of an HTTP/1.1 request stream.
// The result word is registered: it is held in the output register, or in the skid word while that register is full.
// Throughput: one byte per cycle while the skid word is empty; parser state advances once per accepted byte.
// An output register plus one skid word keep accepting while a result waits.
// Reset (rst_ni low, async): request-line phase, length and body count cleared, no words held.
// Uses hrf_pkg, hrf_stream_if, hrf_parser and http_request_framer_assert.svh.
module http_request_framer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hrf_stream_if.sink    in_i,
  hrf_stream_if.source  out_o
);
  import hrf_pkg::*;
  `include "http_request_framer_assert.svh"

  hrf_in_t     in_word;
  hrf_result_t result;
  hrf_result_t out_data_q, skid_data_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_accept, out_pop;

  assign in_word   = in_i.data;
  assign in_i.ready = !skid_valid_q;
  assign in_accept = in_i.valid && in_i.ready;
  assign out_pop   = out_valid_q && out_o.ready;

  hrf_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_accept),
    .data_byte_i (in_word.data_byte),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_accept) begin
        out_data_q <= result;
      end
    end else if (in_accept) begin
      if (out_valid_q) begin
        skid_data_q <= result;
      end else begin
        out_data_q <= result;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `HRF_ASSERT(a_skid_behind_out, skid_valid_q, out_valid_q, "skid word without output word")
  `HRF_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_pop, !skid_valid_q, "skid did not drain")
  `HRF_ASSERT(a_ok_needs_end, in_accept && result.line_ok, result.line_end, "ok without end")
  `HRF_ASSERT(a_done_role, in_accept && result.request_done,
              (result.role == ROLE_DROP) || (result.role == ROLE_BODY), "done on wrong role")

endmodule
